>>> src/indexed_fifo_with_purge_top_assert.svh
// assertion macros for the indexed fifo with purge
`ifndef INDEXED_FIFO_WITH_PURGE_TOP_ASSERT_SVH
`define INDEXED_FIFO_WITH_PURGE_TOP_ASSERT_SVH

// condition on one edge implies a consequence on the same edge
`define IFP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define IFP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> src/ifp_pkg.sv
// shared widths, codes and types for the indexed fifo with purge
package ifp_pkg;

    localparam int KIND_W = 3;
    localparam int DATA_W = 16;
    localparam int POS_W  = 4;
    localparam int QTY_W  = 5;
    localparam int STAT_W = 2;
    localparam int FILL_W = 5;
    localparam int OP_W   = 3;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_FIELD_WIDTH = 16;

    localparam int CMDQ_DEPTH = 2;

    // transaction kinds on the request channel
    localparam logic [KIND_W-1:0] KIND_ENQ    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PURGE  = 3'd4;

    // status codes on the response channel
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // internal operation codes after classification
    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_ENQ    = 3'd1;
    localparam logic [OP_W-1:0] OP_DEQ    = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
    localparam logic [OP_W-1:0] OP_PURGE  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] deadline;
        logic [DATA_W-1:0] destination;
        logic [POS_W-1:0]  position;
        logic [QTY_W-1:0]  quantity;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] out_deadline;
        logic [DATA_W-1:0] out_destination;
        logic [QTY_W-1:0]  left_over;
        logic [FILL_W-1:0] fill;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

>>> src/ifp_req_if.sv
// request channel interface for the indexed fifo with purge
interface ifp_req_if import ifp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] deadline;
    logic [DATA_W-1:0] destination;
    logic [POS_W-1:0]  position;
    logic [QTY_W-1:0]  quantity;

    modport source (
        output valid,
        output kind,
        output deadline,
        output destination,
        output position,
        output quantity,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  deadline,
        input  destination,
        input  position,
        input  quantity,
        output ready
    );

endinterface

>>> src/ifp_rsp_if.sv
// response channel interface for the indexed fifo with purge
interface ifp_rsp_if import ifp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] out_deadline;
    logic [DATA_W-1:0] out_destination;
    logic [QTY_W-1:0]  left_over;
    logic [FILL_W-1:0] fill;

    modport source (
        output valid,
        output status,
        output out_deadline,
        output out_destination,
        output left_over,
        output fill,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  out_deadline,
        input  out_destination,
        input  left_over,
        input  fill,
        output ready
    );

endinterface

>>> src/ifp_front.sv
// front end: accepts request transactions and classifies them into commands
module ifp_front import ifp_pkg::*; (
    ifp_req_if.sink  req,
    input  qstat_t   qstat,
    output logic     push,
    output cmd_t     cmd
);

    assign req.ready = !qstat.full;
    assign push      = req.valid && !qstat.full;

    always_comb
    begin
        cmd.deadline    = req.deadline;
        cmd.destination = req.destination;
        cmd.position    = req.position;
        cmd.quantity    = req.quantity;
        case (req.kind)
            KIND_ENQ:
            begin
                cmd.op = OP_ENQ;
            end
            KIND_DEQ:
            begin
                // a dequeue is a remove at the head that also returns the entry
                cmd.op       = OP_DEQ;
                cmd.position = '0;
                cmd.quantity = QTY_W'(1);
            end
            KIND_READ:
            begin
                cmd.op = OP_READ;
            end
            KIND_REMOVE:
            begin
                cmd.op       = OP_REMOVE;
                cmd.quantity = QTY_W'(1);
            end
            KIND_PURGE:
            begin
                // zero quantity purge changes nothing
                cmd.op = (req.quantity == '0) ? OP_NOP : OP_PURGE;
            end
            default:
            begin
                cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

>>> src/ifp_cmd_queue.sv
// short command queue between front and back end
module ifp_cmd_queue import ifp_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  cmd_t   push_cmd,
    input  logic   pop,
    output cmd_t   head_cmd,
    output logic   head_valid,
    output qstat_t qstat
);

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t             slot_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign qstat.full  = (count_reg == CNT_W'(CMDQ_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_valid  = !qstat.empty;
    assign head_cmd    = slot_reg[rptr_reg];

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && !qstat.empty;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/ifp_back.sv
// back end: entry memory, compaction sequencer and response register
module ifp_back import ifp_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int FIELD_WIDTH = DEF_FIELD_WIDTH
) (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic cmd_valid,
    output logic cmd_pop,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RDATA = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    logic [FIELD_WIDTH-1:0] mem_dl [QUEUE_DEPTH];
    logic [FIELD_WIDTH-1:0] mem_ds [QUEUE_DEPTH];

    logic [1:0]             state_reg, state_next;
    logic [CW-1:0]          occ_reg, occ_next;
    logic [CW-1:0]          rd_reg, rd_next;
    logic [CW-1:0]          wr_reg, wr_next;
    logic                   pend_reg, pend_next;
    logic [QTY_W-1:0]       left_reg, left_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [FIELD_WIDTH-1:0] key_dl_reg, key_dl_next;
    logic [FIELD_WIDTH-1:0] key_ds_reg, key_ds_next;
    logic [FIELD_WIDTH-1:0] cap_dl_reg, cap_dl_next;
    logic [FIELD_WIDTH-1:0] cap_ds_reg, cap_ds_next;
    logic [FIELD_WIDTH-1:0] rdata_dl_reg;
    logic [FIELD_WIDTH-1:0] rdata_ds_reg;
    logic                   res_valid_reg, res_valid_next;
    res_t                   res_reg, res_next;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [FIELD_WIDTH-1:0] mem_wdl;
    logic [FIELD_WIDTH-1:0] mem_wds;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;

    logic                   res_free;
    logic                   res_load;
    res_t                   res_data;
    logic                   hit;
    logic [PW-1:0]          pos_ext;
    logic [PW-1:0]          occ_ext;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign res_free  = !res_valid_reg || res_ready;
    assign pos_ext   = PW'(cmd.position);
    assign occ_ext   = PW'(occ_reg);

    // remove and dequeue drop the first entry scanned, purge drops matching ones
    assign hit = (left_reg != '0) &&
                 ((op_reg != OP_PURGE) ||
                  ((rdata_dl_reg == key_dl_reg) && (rdata_ds_reg == key_ds_reg)));

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        pend_next      = pend_reg;
        left_next      = left_reg;
        op_next        = op_reg;
        key_dl_next    = key_dl_reg;
        key_ds_next    = key_ds_reg;
        cap_dl_next    = cap_dl_reg;
        cap_ds_next    = cap_ds_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = wr_reg[AW-1:0];
        mem_wdl        = rdata_dl_reg;
        mem_wds        = rdata_ds_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_reg[AW-1:0];
        cmd_pop        = 1'b0;
        res_load       = 1'b0;
        res_data       = '{status: ST_OK, out_deadline: '0, out_destination: '0,
                           left_over: '0, fill: FILL_W'(occ_reg)};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && res_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_ENQ:
                        begin
                            res_load = 1'b1;
                            if (occ_reg == CW'(QUEUE_DEPTH))
                            begin
                                res_data.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = occ_reg[AW-1:0];
                                mem_wdl       = FIELD_WIDTH'(cmd.deadline);
                                mem_wds       = FIELD_WIDTH'(cmd.destination);
                                occ_next      = occ_reg + CW'(1);
                                res_data.fill = FILL_W'(occ_reg + CW'(1));
                            end
                        end
                        OP_DEQ, OP_READ, OP_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_load        = 1'b1;
                                res_data.status = ST_EMPTY;
                            end
                            else if (pos_ext >= occ_ext)
                            begin
                                res_load        = 1'b1;
                                res_data.status = ST_RANGE;
                            end
                            else if (cmd.op == OP_READ)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_ext[AW-1:0];
                                state_next = S_RDATA;
                            end
                            else
                            begin
                                rd_next    = CW'(pos_ext);
                                wr_next    = CW'(pos_ext);
                                pend_next  = 1'b0;
                                left_next  = cmd.quantity;
                                op_next    = cmd.op;
                                state_next = S_SCAN;
                            end
                        end
                        OP_PURGE:
                        begin
                            rd_next     = '0;
                            wr_next     = '0;
                            pend_next   = 1'b0;
                            left_next   = cmd.quantity;
                            op_next     = OP_PURGE;
                            key_dl_next = FIELD_WIDTH'(cmd.deadline);
                            key_ds_next = FIELD_WIDTH'(cmd.destination);
                            state_next  = S_SCAN;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_RDATA:
            begin
                res_load                 = 1'b1;
                res_data.out_deadline    = DATA_W'(rdata_dl_reg);
                res_data.out_destination = DATA_W'(rdata_ds_reg);
                state_next               = S_IDLE;
            end
            S_SCAN:
            begin
                // read one entry ahead while the previous one is kept or dropped
                if (rd_reg < occ_reg)
                begin
                    mem_re    = 1'b1;
                    rd_next   = rd_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (hit)
                    begin
                        left_next   = left_reg - QTY_W'(1);
                        cap_dl_next = rdata_dl_reg;
                        cap_ds_next = rdata_ds_reg;
                    end
                    else
                    begin
                        mem_we  = 1'b1;
                        wr_next = wr_reg + CW'(1);
                    end
                end
                else if (rd_reg >= occ_reg)
                begin
                    occ_next      = wr_reg;
                    res_load      = 1'b1;
                    res_data.fill = FILL_W'(wr_reg);
                    if (op_reg == OP_DEQ)
                    begin
                        res_data.out_deadline    = DATA_W'(cap_dl_reg);
                        res_data.out_destination = DATA_W'(cap_ds_reg);
                    end
                    if (op_reg == OP_PURGE)
                    begin
                        res_data.left_over = left_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_next       = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            pend_reg      <= 1'b0;
            left_reg      <= '0;
            op_reg        <= OP_NOP;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            pend_reg      <= pend_next;
            left_reg      <= left_next;
            op_reg        <= op_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_dl_reg <= key_dl_next;
        key_ds_reg <= key_ds_next;
        cap_dl_reg <= cap_dl_next;
        cap_ds_reg <= cap_ds_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_dl[mem_waddr] <= mem_wdl;
            mem_ds[mem_waddr] <= mem_wds;
        end
        if (mem_re)
        begin
            rdata_dl_reg <= mem_dl[mem_raddr];
            rdata_ds_reg <= mem_ds[mem_raddr];
        end
    end

endmodule

>>> src/indexed_fifo_with_purge_top.sv
// enqueue, errors and no-op kinds pass the command queue and the response register, a read
// also the memory read register; dequeue, remove and purge first scan from the start index
// to the fill: the compaction pass reads one entry per cycle and writes back each kept entry
// throughput: one per cycle for enqueue and errors while responses are taken; a read or a
// compaction keeps the back end busy until it responds; a 2-entry command queue absorbs requests
// reset clears occupancy, the command queue and the response valid flag, not the entries
`include "indexed_fifo_with_purge_top_assert.svh"

// top level of the indexed fifo with purge
module indexed_fifo_with_purge_top import ifp_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int FIELD_WIDTH = DEF_FIELD_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    ifp_req_if.sink    req,
    ifp_rsp_if.source  rsp
);

    qstat_t qstat;
    logic   push;
    cmd_t   push_cmd;
    cmd_t   head_cmd;
    logic   head_valid;
    logic   pop;
    res_t   res;

    ifp_front u_front (
        .req   (req),
        .qstat (qstat),
        .push  (push),
        .cmd   (push_cmd)
    );

    ifp_cmd_queue u_cmd_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .qstat      (qstat)
    );

    ifp_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FIELD_WIDTH (FIELD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (head_valid),
        .cmd_pop   (pop),
        .res_valid (rsp.valid),
        .res_ready (rsp.ready),
        .res       (res)
    );

    assign rsp.status          = res.status;
    assign rsp.out_deadline    = res.out_deadline;
    assign rsp.out_destination = res.out_destination;
    assign rsp.left_over       = res.left_over;
    assign rsp.fill            = res.fill;

    `IFP_ASSERT_IMPLIES(a_full_fill, rsp.valid && (rsp.status == ST_FULL),
        rsp.fill == FILL_W'(QUEUE_DEPTH), "full status with queue not full")

    `IFP_ASSERT_IMPLIES(a_empty_fill, rsp.valid && (rsp.status == ST_EMPTY),
        rsp.fill == '0, "empty status with entries present")

    `IFP_ASSERT_NEVER(a_err_data, rsp.valid && (rsp.status != ST_OK) &&
        ((rsp.out_deadline != '0) || (rsp.out_destination != '0) || (rsp.left_over != '0)),
        "error response carries data")

    `IFP_ASSERT_NEVER(a_pop_empty, pop && !head_valid, "back end popped an empty command queue")

endmodule

>>> test/indexed_fifo_with_purge_top_tb.sv
// testbench for the indexed fifo with purge: shadow queue, random traffic and response checks
`timescale 1ns / 1ps

module indexed_fifo_with_purge_top_tb;
    import ifp_pkg::*;

    localparam int RANDOM_ITEMS = 928;
    localparam int CALM_FROM    = 830;
    localparam int PHASE_LEN    = 40;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 2 * (DEF_QUEUE_DEPTH + 3);
    localparam int CYCLE_LIMIT  = 200000;
    localparam int KIND_MAX     = (1 << KIND_W) - 1;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

    // shadow copy of the queue, predicts one response per request transaction
    class fifo_shadow;
        logic [DATA_W-1:0] slot_deadline [DEF_QUEUE_DEPTH];
        logic [DATA_W-1:0] slot_destination [DEF_QUEUE_DEPTH];
        int unsigned       entries;
        res_t              pending_rsp [$];
        int unsigned       errors;

        function new();
            entries = 0;
            errors  = 0;
        endfunction

        function void close_gap(int unsigned idx);
            for (int unsigned i = idx; i + 1 < entries; i++)
            begin
                slot_deadline[i]    = slot_deadline[i + 1];
                slot_destination[i] = slot_destination[i + 1];
            end
            entries--;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] deadline,
                                   logic [DATA_W-1:0] destination,
                                   logic [POS_W-1:0] position, logic [QTY_W-1:0] quantity);
            res_t        r;
            int unsigned idx;
            r = '0;
            case (kind)
                KIND_ENQ:
                begin
                    if (entries >= DEF_QUEUE_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        slot_deadline[entries]    = deadline;
                        slot_destination[entries] = destination;
                        entries++;
                    end
                end
                KIND_DEQ:
                begin
                    if (entries == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.out_deadline    = slot_deadline[0];
                        r.out_destination = slot_destination[0];
                        close_gap(0);
                    end
                end
                KIND_READ, KIND_REMOVE:
                begin
                    if (entries == 0)
                        r.status = ST_EMPTY;
                    else if (position >= entries)
                        r.status = ST_RANGE;
                    else if (kind == KIND_READ)
                    begin
                        r.out_deadline    = slot_deadline[position];
                        r.out_destination = slot_destination[position];
                    end
                    else
                        close_gap(position);
                end
                KIND_PURGE:
                begin
                    // scan from the head, a removal keeps the index where it is
                    r.left_over = quantity;
                    idx = 0;
                    while (r.left_over != 0 && idx < entries)
                    begin
                        if (slot_deadline[idx] == deadline &&
                            slot_destination[idx] == destination)
                        begin
                            close_gap(idx);
                            r.left_over = r.left_over - 1'b1;
                        end
                        else
                            idx++;
                    end
                end
                default: ;
            endcase
            r.fill = FILL_W'(entries);
            pending_rsp.push_back(r);
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_response(res_t got);
            res_t want;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response with nothing pending, expected none, actual status %0h fill %0h",
                         $time, got.status, got.fill);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status)
                flag("status", want.status, got.status);
            if (got.out_deadline !== want.out_deadline)
                flag("out_deadline", want.out_deadline, got.out_deadline);
            if (got.out_destination !== want.out_destination)
                flag("out_destination", want.out_destination, got.out_destination);
            if (got.left_over !== want.left_over)
                flag("left_over", want.left_over, got.left_over);
            if (got.fill !== want.fill)
                flag("fill", want.fill, got.fill);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ifp_req_if req_ch ();
    ifp_rsp_if rsp_ch ();

    indexed_fifo_with_purge_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    fifo_shadow  shadow = new();
    bit          bursty = 1'b1;
    bit          hold_off = 1'b0;
    int unsigned cycles = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status          = rsp_ch.status;
            got.out_deadline    = rsp_ch.out_deadline;
            got.out_destination = rsp_ch.out_destination;
            got.left_over       = rsp_ch.left_over;
            got.fill            = rsp_ch.fill;
            shadow.check_response(got);
        end
    end

    // response side: random stalls, plus a long hold-off on request
    initial
    begin
        int held;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                rsp_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            else if (bursty && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // mostly a small set of keys so that purges find matches
    function automatic logic [DATA_W-1:0] pick_key();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h00F0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] deadline,
                                logic [DATA_W-1:0] destination,
                                logic [POS_W-1:0] position, logic [QTY_W-1:0] quantity);
        if (bursty && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.deadline    <= deadline;
        req_ch.destination <= destination;
        req_ch.position    <= position;
        req_ch.quantity    <= quantity;
        do
            @(posedge clk);
        while (!req_ch.ready);
        shadow.note_request(kind, deadline, destination, position, quantity);
    endtask

    initial
    begin
        mix_t              mix;
        int                enq_share;
        int                pick;
        logic [KIND_W-1:0] kind;

        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= KIND_ENQ;
        req_ch.deadline    <= '0;
        req_ch.destination <= '0;
        req_ch.position    <= '0;
        req_ch.quantity    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue errors and a purge with nothing to match
        send_request(KIND_DEQ, 16'h0000, 16'h0000, 4'd0, 5'd0);
        send_request(KIND_READ, 16'h0000, 16'h0000, 4'd0, 5'd0);
        send_request(KIND_REMOVE, 16'h0000, 16'h0000, 4'd0, 5'd0);
        send_request(KIND_PURGE, 16'h0000, 16'h0000, 4'd0, 5'd5);
        send_request(KIND_ENQ, 16'h0000, 16'h0000, 4'd0, 5'd0);
        send_request(KIND_ENQ, 16'hFFFF, 16'hFFFF, 4'd15, 5'd16);
        send_request(KIND_ENQ, 16'h1234, 16'hABCD, 4'd0, 5'd0);
        send_request(KIND_ENQ, 16'hFFFF, 16'hFFFF, 4'd0, 5'd0);
        send_request(KIND_READ, 16'h0000, 16'h0000, 4'd0, 5'd0);
        send_request(KIND_READ, 16'h0000, 16'h0000, 4'd3, 5'd0);
        // index at and beyond the fill
        send_request(KIND_READ, 16'h0000, 16'h0000, 4'd4, 5'd0);
        send_request(KIND_READ, 16'h0000, 16'h0000, 4'd15, 5'd0);
        send_request(KIND_REMOVE, 16'h0000, 16'h0000, 4'd15, 5'd0);
        // zero quantity removes nothing, then more quantity than matches
        send_request(KIND_PURGE, 16'hFFFF, 16'hFFFF, 4'd0, 5'd0);
        send_request(KIND_PURGE, 16'hFFFF, 16'hFFFF, 4'd0, 5'd16);
        send_request(KIND_REMOVE, 16'h0000, 16'h0000, 4'd1, 5'd0);
        for (int k = int'(KIND_PURGE) + 1; k <= KIND_MAX; k++)
            send_request(KIND_W'(k), pick_key(), pick_key(), POS_W'($urandom),
                         QTY_W'($urandom));
        send_request(KIND_DEQ, 16'h0000, 16'h0000, 4'd0, 5'd0);
        // remove of the only entry
        send_request(KIND_ENQ, 16'h5A5A, 16'hA5A5, 4'd0, 5'd0);
        send_request(KIND_REMOVE, 16'h0000, 16'h0000, 4'd0, 5'd0);
        send_request(KIND_READ, 16'h0000, 16'h0000, 4'd0, 5'd0);

        mix = MIX_GROW;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                mix = mix_t'($urandom_range(0, 2));
                bursty = (n < CALM_FROM) && ($urandom_range(0, 3) != 0);
            end
            if (n == 150 || n == 600)
                hold_off = 1'b1;
            case (mix)
                MIX_GROW:   enq_share = 80;
                MIX_SHRINK: enq_share = 15;
                default:    enq_share = 40;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < enq_share)
                kind = KIND_ENQ;
            else if (pick >= 97)
                kind = KIND_W'($urandom_range(int'(KIND_PURGE) + 1, KIND_MAX));
            else
            begin
                case ($urandom_range(0, 3))
                    0: kind = KIND_DEQ;
                    1: kind = KIND_READ;
                    2: kind = KIND_REMOVE;
                    default: kind = KIND_PURGE;
                endcase
            end
            send_request(kind, pick_key(), pick_key(), POS_W'($urandom_range(0, 15)),
                         QTY_W'($urandom_range(0, 16)));
        end
        req_ch.valid <= 1'b0;

        while (shadow.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
